@@ rtl/gda_pkg.sv @@
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar functions of the date adder.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int CMD_W   = 3;
    localparam int YEAR_W  = 15;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int AMT_W   = 12;
    localparam int WIDE_W  = 23;
    localparam int PROD_W  = 22;
    localparam int FACT_W  = 10;
    localparam int STEP_W  = 15;
    localparam int DIVR_W  = 9;
    localparam int QUO_W   = 9;
    localparam int REC_W   = 13;
    localparam int RPROD_W = 28;

    localparam int SHIFT_YEAR  = 21;
    localparam int SHIFT_MONTH = 16;

    localparam logic [YEAR_W-1:0] YEAR_MAX   = 15'd32767;
    localparam logic [DIVR_W-1:0] DIV_YEAR   = 9'd400;
    localparam logic [DIVR_W-1:0] DIV_MONTH  = 9'd12;
    localparam logic [DIVR_W-1:0] R400_LAST  = 9'd399;
    localparam logic [REC_W-1:0]  RECIP_YEAR  = 13'd5243;
    localparam logic [REC_W-1:0]  RECIP_MONTH = 13'd5462;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef enum logic [CMD_W-1:0] {
        UNIT_DAYS      = 3'd0,
        UNIT_WEEKS     = 3'd1,
        UNIT_MONTHS    = 3'd2,
        UNIT_YEARS     = 3'd3,
        UNIT_DECADES   = 3'd4,
        UNIT_CENTURIES = 3'd5,
        UNIT_MILLENNIA = 3'd6,
        UNIT_NONE      = 3'd7
    } gda_unit_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV,
        OP_R400,
        OP_CLAMP,
        OP_STEP,
        OP_MINIT,
        OP_MAPPLY,
        OP_MUL,
        OP_YADD,
        OP_SAT
    } gda_op_t;

    typedef struct packed {
        logic steps_zero;
        logic day_mode;
        logic month_mode;
        logic year_mode;
    } gda_status_t;

    typedef logic [DAY_W-1:0] gda_mlen_t [12];

    localparam gda_mlen_t MONTH_LEN = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // leap test from the year modulo 400
    function automatic logic leap_of(input logic [DIVR_W-1:0] r400);
        logic by4;
        by4 = (r400[1:0] == 2'd0);
        return (r400 == '0) ||
               (by4 && (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300));
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        logic [MONTH_W-1:0] idx;
        idx = month - 4'd1;
        if (month == MONTH_FEB)
            return leap ? 5'd29 : 5'd28;
        return MONTH_LEN[idx];
    endfunction

endpackage

@@ rtl/gda_ctrl.sv @@
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer of the date adder: issues at most one datapath operation per cycle.
// ----------------------------------------------------------------------------
module gda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gda_pkg::gda_status_t status,
    output gda_pkg::gda_op_t    op,
    output logic                busy,
    output logic                done
);
    import gda_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_MOD0   = 14'b00000000000010,
        S_R400A  = 14'b00000000000100,
        S_CLAMPA = 14'b00000000001000,
        S_STEP   = 14'b00000000010000,
        S_MINIT  = 14'b00000000100000,
        S_MDIV   = 14'b00000001000000,
        S_MAPPLY = 14'b00000010000000,
        S_MUL    = 14'b00000100000000,
        S_YADD   = 14'b00001000000000,
        S_SAT    = 14'b00010000000000,
        S_MOD1   = 14'b00100000000000,
        S_R400B  = 14'b01000000000000,
        S_DONE   = 14'b10000000000000
    } gda_state_t;

    gda_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LOAD;
                    state_next = S_MOD0;
                end
            end
            S_MOD0:
            begin
                op         = OP_DIV;
                state_next = S_R400A;
            end
            S_R400A:
            begin
                op         = OP_R400;
                state_next = S_CLAMPA;
            end
            S_CLAMPA:
            begin
                op = OP_CLAMP;
                if (status.day_mode)
                    state_next = S_STEP;
                else if (status.month_mode)
                    state_next = S_MINIT;
                else if (status.year_mode)
                    state_next = S_MUL;
                else
                    state_next = S_SAT;
            end
            S_STEP:
            begin
                if (status.steps_zero)
                    state_next = S_SAT;
                else
                    op = OP_STEP;
            end
            S_MINIT:
            begin
                op         = OP_MINIT;
                state_next = S_MDIV;
            end
            S_MDIV:
            begin
                op         = OP_DIV;
                state_next = S_MAPPLY;
            end
            S_MAPPLY:
            begin
                op         = OP_MAPPLY;
                state_next = S_SAT;
            end
            S_MUL:
            begin
                op         = OP_MUL;
                state_next = S_YADD;
            end
            S_YADD:
            begin
                op         = OP_YADD;
                state_next = S_SAT;
            end
            S_SAT:
            begin
                op         = OP_SAT;
                state_next = S_MOD1;
            end
            S_MOD1:
            begin
                op         = OP_DIV;
                state_next = S_R400B;
            end
            S_R400B:
            begin
                op         = OP_R400;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // final clamp is folded into the output path of the datapath
    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

@@ rtl/gda_datapath.sv @@
// ----------------------------------------------------------------------------
// gda_datapath
// Date registers, day stepper, reciprocal divider by 400 or 12 and year
// multiplier.
// ----------------------------------------------------------------------------
module gda_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  gda_pkg::gda_op_t                  op,
    input  logic [gda_pkg::CMD_W-1:0]         cmd,
    input  logic [gda_pkg::YEAR_W-1:0]        start_year,
    input  logic [gda_pkg::MONTH_W-1:0]       start_month,
    input  logic [gda_pkg::DAY_W-1:0]         start_day,
    input  logic [gda_pkg::AMT_W-1:0]         amount,
    output gda_pkg::gda_status_t              status,
    output logic [gda_pkg::YEAR_W-1:0]        new_year,
    output logic [gda_pkg::MONTH_W-1:0]       new_month,
    output logic [gda_pkg::DAY_W-1:0]         new_day,
    output logic                              year_overflow
);
    import gda_pkg::*;

    logic [CMD_W-1:0]   cmd_reg;
    logic [AMT_W-1:0]   amt_reg;
    logic [WIDE_W-1:0]  y_reg;
    logic [MONTH_W-1:0] m_reg;
    logic [DAY_W-1:0]   d_reg;
    logic [DIVR_W-1:0]  r400_reg;
    logic [STEP_W-1:0]  steps_reg;
    logic [YEAR_W-1:0]  dvd_reg;
    logic [DIVR_W-1:0]  dvs_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic               ovf_reg;

    logic [YEAR_W-1:0]  y_norm;
    logic [MONTH_W-1:0] m_norm;
    logic [DAY_W-1:0]   d_norm;
    logic [STEP_W-1:0]  steps_init;
    logic               div_year;
    logic [REC_W-1:0]   recip;
    logic [RPROD_W-1:0] rprod;
    logic [QUO_W-1:0]   quo_calc;
    logic [YEAR_W-1:0]  quo_mul;
    logic [DIVR_W-1:0]  rem_val;
    logic [DAY_W-1:0]   dim_now;
    logic [DAY_W-1:0]   d_clamp;
    logic [FACT_W-1:0]  factor;
    logic               y_big;
    logic [YEAR_W-1:0]  y_sat;
    gda_unit_t          unit;

    assign unit = gda_unit_t'(cmd_reg);

    assign y_norm = (start_year == '0) ? YEAR_W'(1) : start_year;
    assign m_norm = (start_month == '0) ? 4'd1 :
                    (start_month > MONTH_DEC) ? MONTH_DEC : start_month;
    assign d_norm = (start_day == '0) ? 5'd1 : start_day;
    assign steps_init = (gda_unit_t'(cmd) == UNIT_WEEKS) ?
                        ({amount, 3'b000} - {3'b000, amount}) : {3'b000, amount};

    // quotient by reciprocal multiplication, exact over the dividend range
    assign div_year = (dvs_reg == DIV_YEAR);
    assign recip    = div_year ? RECIP_YEAR : RECIP_MONTH;
    assign rprod    = {13'd0, dvd_reg} * {15'd0, recip};
    assign quo_calc = div_year ? QUO_W'(rprod[RPROD_W-1:SHIFT_YEAR]) :
                                 rprod[SHIFT_MONTH +: QUO_W];
    assign quo_mul  = {6'd0, quo_reg} * {6'd0, dvs_reg};
    assign rem_val  = DIVR_W'(dvd_reg - quo_mul);

    assign dim_now = days_in(m_reg, leap_of(r400_reg));
    assign d_clamp = (d_reg > dim_now) ? dim_now : d_reg;

    always_comb
    begin
        case (unit)
            UNIT_DECADES:   factor = 10'd10;
            UNIT_CENTURIES: factor = 10'd100;
            UNIT_MILLENNIA: factor = 10'd1000;
            default:        factor = 10'd1;
        endcase
    end

    assign y_big = (y_reg > {8'd0, YEAR_MAX});
    assign y_sat = y_big ? YEAR_MAX : y_reg[YEAR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovf_reg <= 1'b0;
        else
        begin
            case (op)
                OP_LOAD:
                begin
                    ovf_reg <= 1'b0;
                end
                OP_SAT:
                begin
                    ovf_reg <= y_big;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cmd_reg   <= cmd;
                amt_reg   <= amount;
                y_reg     <= {8'd0, y_norm};
                m_reg     <= m_norm;
                d_reg     <= d_norm;
                steps_reg <= steps_init;
                dvd_reg   <= y_norm;
                dvs_reg   <= DIV_YEAR;
            end
            OP_DIV:
            begin
                quo_reg <= quo_calc;
            end
            OP_R400:
            begin
                r400_reg <= rem_val;
            end
            OP_CLAMP:
            begin
                d_reg <= d_clamp;
            end
            OP_STEP:
            begin
                steps_reg <= steps_reg - 15'd1;
                if (d_reg >= dim_now)
                begin
                    d_reg <= 5'd1;
                    if (m_reg == MONTH_DEC)
                    begin
                        m_reg    <= 4'd1;
                        y_reg    <= y_reg + 23'd1;
                        r400_reg <= (r400_reg == R400_LAST) ? '0 : r400_reg + 9'd1;
                    end
                    else
                    begin
                        m_reg <= m_reg + 4'd1;
                    end
                end
                else
                begin
                    d_reg <= d_reg + 5'd1;
                end
            end
            OP_MINIT:
            begin
                dvd_reg <= {11'd0, m_reg} + {3'd0, amt_reg} - 15'd1;
                dvs_reg <= DIV_MONTH;
            end
            OP_MAPPLY:
            begin
                y_reg <= y_reg + {14'd0, quo_reg};
                m_reg <= rem_val[MONTH_W-1:0] + 4'd1;
            end
            OP_MUL:
            begin
                prod_reg <= {10'd0, amt_reg} * {12'd0, factor};
            end
            OP_YADD:
            begin
                y_reg <= y_reg + {1'b0, prod_reg};
            end
            OP_SAT:
            begin
                y_reg   <= {8'd0, y_sat};
                dvd_reg <= y_sat;
                dvs_reg <= DIV_YEAR;
            end
            default:
            begin
            end
        endcase
    end

    assign status.steps_zero = (steps_reg == '0);
    assign status.day_mode   = (unit == UNIT_DAYS) || (unit == UNIT_WEEKS);
    assign status.month_mode = (unit == UNIT_MONTHS);
    assign status.year_mode  = (unit == UNIT_YEARS) || (unit == UNIT_DECADES) ||
                               (unit == UNIT_CENTURIES) || (unit == UNIT_MILLENNIA);

    assign new_year      = y_reg[YEAR_W-1:0];
    assign new_month     = m_reg;
    assign new_day       = d_clamp;
    assign year_overflow = ovf_reg;

endmodule

@@ rtl/gregorian_date_adder.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_adder
// Days and weeks step one day per cycle over amount (or 7*amount) days; months
// take an init, divide and apply step, years through millennia a multiply and
// an add step, the unused unit code none. Year mod 400 is taken by reciprocal
// multiplication before and after the addition, with a divide and a remainder
// step each time. One item at a time; busy stays high until done, which pulses
// for one cycle, and the next item is accepted in the cycle after done at the
// earliest. Reset returns the sequencer to idle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module gregorian_date_adder (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gda_pkg::CMD_W-1:0]    cmd,
    input  logic [gda_pkg::YEAR_W-1:0]   start_year,
    input  logic [gda_pkg::MONTH_W-1:0]  start_month,
    input  logic [gda_pkg::DAY_W-1:0]    start_day,
    input  logic [gda_pkg::AMT_W-1:0]    amount,
    output logic                         busy,
    output logic                         done,
    output logic [gda_pkg::YEAR_W-1:0]   new_year,
    output logic [gda_pkg::MONTH_W-1:0]  new_month,
    output logic [gda_pkg::DAY_W-1:0]    new_day,
    output logic                         year_overflow
);
    import gda_pkg::*;

    gda_op_t     op;
    gda_status_t status;

    gda_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .op     (op),
        .busy   (busy),
        .done   (done)
    );

    gda_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .cmd           (cmd),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .amount        (amount),
        .status        (status),
        .new_year      (new_year),
        .new_month     (new_month),
        .new_day       (new_day),
        .year_overflow (year_overflow)
    );

endmodule

@@ tb/gda_checker.sv @@
// ----------------------------------------------------------------------------
// gda_checker
// Watches the command and result ports of the date adder. Each accepted item
// is run through a calendar predictor, and the expected date is queued. Each
// done strobe is compared field by field with the oldest queued date. The
// mismatch count and the number of dates still pending go to the top.
// ----------------------------------------------------------------------------
module gda_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [gda_pkg::CMD_W-1:0]     cmd,
    input  logic [gda_pkg::YEAR_W-1:0]    start_year,
    input  logic [gda_pkg::MONTH_W-1:0]   start_month,
    input  logic [gda_pkg::DAY_W-1:0]     start_day,
    input  logic [gda_pkg::AMT_W-1:0]     amount,
    input  logic                          done,
    input  logic [gda_pkg::YEAR_W-1:0]    new_year,
    input  logic [gda_pkg::MONTH_W-1:0]   new_month,
    input  logic [gda_pkg::DAY_W-1:0]     new_day,
    input  logic                          year_overflow,
    output int                            mismatches,
    output int                            pending
);
    import gda_pkg::*;

    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               ovf;
    } date_t;

    date_t expected_dates[$];

    initial
    begin
        mismatches = 0;
        pending    = 0;
    end

    function automatic bit is_leap(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
        case (m)
            2:           return is_leap(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic date_t date_after_add(input logic [CMD_W-1:0]   unit_code,
                                             input logic [YEAR_W-1:0]  yr,
                                             input logic [MONTH_W-1:0] mo,
                                             input logic [DAY_W-1:0]   dy,
                                             input logic [AMT_W-1:0]   amt);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        int unsigned n;
        int unsigned lim;
        date_t r;
        y = yr;
        m = mo;
        d = dy;
        // normalize the start date
        if (y == 0) y = 1;
        if (m == 0) m = 1;
        if (m > 12) m = 12;
        if (d == 0) d = 1;
        lim = month_days(y, m);
        if (d > lim) d = lim;
        case (gda_unit_t'(unit_code))
            UNIT_DAYS, UNIT_WEEKS:
            begin
                n = (gda_unit_t'(unit_code) == UNIT_WEEKS) ? amt * 7 : amt;
                while (n != 0)
                begin
                    if (d >= month_days(y, m))
                    begin
                        d = 1;
                        if (m == 12)
                        begin
                            m = 1;
                            y = y + 1;
                        end
                        else
                            m = m + 1;
                    end
                    else
                        d = d + 1;
                    n = n - 1;
                end
            end
            UNIT_MONTHS:
            begin
                m = m + amt;
                y = y + (m - 1) / 12;
                m = (m - 1) % 12 + 1;
            end
            UNIT_YEARS:     y = y + amt;
            UNIT_DECADES:   y = y + amt * 10;
            UNIT_CENTURIES: y = y + amt * 100;
            UNIT_MILLENNIA: y = y + amt * 1000;
            default: ;
        endcase
        r.ovf = (y > YEAR_MAX);
        if (r.ovf) y = YEAR_MAX;
        lim = month_days(y, m);
        if (d > lim) d = lim;
        r.year  = y[YEAR_W-1:0];
        r.month = m[MONTH_W-1:0];
        r.day   = d[DAY_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk)
    begin
        date_t want;
        if (rst_n)
        begin
            // the result of an earlier item comes before a new item is queued
            if (done)
            begin
                if (expected_dates.size() == 0)
                    report_mismatch($sformatf("result %0d-%0d-%0d ovf %0b with no item pending",
                                              new_year, new_month, new_day, year_overflow));
                else
                begin
                    want = expected_dates.pop_front();
                    if (new_year !== want.year)
                        report_mismatch($sformatf("new_year got %0d expected %0d",
                                                  new_year, want.year));
                    if (new_month !== want.month)
                        report_mismatch($sformatf("new_month got %0d expected %0d",
                                                  new_month, want.month));
                    if (new_day !== want.day)
                        report_mismatch($sformatf("new_day got %0d expected %0d",
                                                  new_day, want.day));
                    if (year_overflow !== want.ovf)
                        report_mismatch($sformatf("year_overflow got %0b expected %0b",
                                                  year_overflow, want.ovf));
                end
            end
            if (start && !busy)
                expected_dates.push_back(date_after_add(cmd, start_year, start_month,
                                                        start_day, amount));
            pending = expected_dates.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of the Gregorian date adder. A directed set of calendar corner
// cases is followed by random dates and amounts in three phases of sender
// idling. A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import gda_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [CMD_W-1:0]   cmd;
    logic [YEAR_W-1:0]  start_year;
    logic [MONTH_W-1:0] start_month;
    logic [DAY_W-1:0]   start_day;
    logic [AMT_W-1:0]   amount;
    logic               busy;
    logic               done;
    logic [YEAR_W-1:0]  new_year;
    logic [MONTH_W-1:0] new_month;
    logic [DAY_W-1:0]   new_day;
    logic               year_overflow;
    int                 mismatches;
    int                 pending;
    int                 idle_pct;
    int                 item_idx;

    gregorian_date_adder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .amount        (amount),
        .busy          (busy),
        .done          (done),
        .new_year      (new_year),
        .new_month     (new_month),
        .new_day       (new_day),
        .year_overflow (year_overflow)
    );

    gda_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .amount        (amount),
        .done          (done),
        .new_year      (new_year),
        .new_month     (new_month),
        .new_day       (new_day),
        .year_overflow (year_overflow),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        #150_000_000;
        $display("Mismatches found");
        $finish;
    end

    // present one item from a falling edge and hold it until the block is no longer busy
    task automatic send_item(input gda_unit_t u, input int y, input int m,
                             input int d, input int a);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        cmd         <= u;
        start_year  <= y[YEAR_W-1:0];
        start_month <= m[MONTH_W-1:0];
        start_day   <= d[DAY_W-1:0];
        amount      <= a[AMT_W-1:0];
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random_item();
        gda_unit_t u;
        int y;
        int m;
        int d;
        int a;
        u = gda_unit_t'($urandom_range(7));
        if ($urandom_range(99) < 85)
        begin
            case ($urandom_range(3))
                0:       y = $urandom_range(32000, 32767);
                1:       y = $urandom_range(1, 3000);
                default: y = $urandom_range(1, 32767);
            endcase
            m = $urandom_range(1, 12);
            d = ($urandom_range(99) < 70) ? $urandom_range(1, 28) : $urandom_range(29, 31);
        end
        else
        begin
            // raw fields, out-of-range values included
            y = $urandom_range(0, 32767);
            m = $urandom_range(0, 15);
            d = $urandom_range(0, 31);
        end
        if (u == UNIT_DAYS || u == UNIT_WEEKS)
            a = (item_idx % 25 == 7) ? $urandom_range(0, 4095) : $urandom_range(0, 500);
        else
            a = ($urandom_range(3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 4095);
        send_item(u, y, m, d, a);
        item_idx = item_idx + 1;
    endtask

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = UNIT_DAYS;
        start_year  = '0;
        start_month = '0;
        start_day   = '0;
        amount      = '0;
        idle_pct    = 34;
        item_idx    = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed corner cases
        send_item(UNIT_DAYS,      1999, 12, 31, 0);
        send_item(UNIT_DAYS,      1999, 12, 31, 1);
        send_item(UNIT_DAYS,      2000,  2, 28, 1);
        send_item(UNIT_DAYS,      1900,  2, 28, 1);
        send_item(UNIT_DAYS,      2024,  1, 31, 4095);
        send_item(UNIT_WEEKS,    32700,  3,  1, 4095);
        send_item(UNIT_WEEKS,     2023, 12, 28, 1);
        send_item(UNIT_MONTHS,    2024,  1, 31, 1);
        send_item(UNIT_MONTHS,       1, 12, 31, 4095);
        send_item(UNIT_MONTHS,    2023,  1, 31, 13);
        send_item(UNIT_YEARS,     2024,  2, 29, 1);
        send_item(UNIT_YEARS,    32767,  1,  1, 4095);
        send_item(UNIT_DECADES,      1,  1,  1, 4095);
        send_item(UNIT_DECADES,      7,  5, 31, 3276);
        send_item(UNIT_CENTURIES, 2000,  2, 29, 100);
        send_item(UNIT_MILLENNIA,  767, 12, 31, 32);
        send_item(UNIT_MILLENNIA, 2000,  2, 29, 4095);
        send_item(UNIT_NONE,         0,  0,  0, 4095);
        send_item(UNIT_NONE,     32767, 15, 31, 0);
        send_item(UNIT_DAYS,         0,  0,  0, 5);
        send_item(UNIT_MONTHS,    1234, 13, 31, 0);
        send_item(UNIT_YEARS,     2023,  2, 31, 0);
        send_item(UNIT_DAYS,      2023,  4, 31, 1);
        send_item(UNIT_DAYS,     32767, 12, 31, 1);

        repeat (26) send_random_item();
        idle_pct = 70;
        repeat (26) send_random_item();
        idle_pct = 0;
        repeat (26) send_random_item();

        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (60) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/gda_pkg.sv
rtl/gda_ctrl.sv
rtl/gda_datapath.sv
rtl/gregorian_date_adder.sv
tb/gda_checker.sv
tb/tb.sv
